### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define MCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MCK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCK_ASSERT(lbl, prop, msg)
`define MCK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/mck_pkg.sv
package mck_pkg;

  localparam int STORED_W    = 24;  // pattern bits held in the code table
  localparam int UNITS_W     = 5;   // pattern length, up to 19 units
  localparam int UNIT_MS_W   = 11;
  localparam int WPM_W       = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WPM_W-1:0] WPM_RESET   = 6'd20;
  localparam logic [7:0]       CH_LOWER_A  = 8'h61;
  localparam logic [7:0]       CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0]       CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic                hit;
    logic [UNITS_W-1:0]  units;
    logic [STORED_W-1:0] bits;
  } code_entry_t;

  // Fixed Morse table, folded character in, length and key pattern out.
  function automatic code_entry_t code_lookup(input logic [7:0] ch);
    code_entry_t e;
    e.hit = 1'b1;
    case (ch)
      8'h41: begin e.units = 5'd5;  e.bits = 24'hB80000; end
      8'h42: begin e.units = 5'd9;  e.bits = 24'hEA8000; end
      8'h43: begin e.units = 5'd11; e.bits = 24'hEBA000; end
      8'h44: begin e.units = 5'd7;  e.bits = 24'hEA0000; end
      8'h45: begin e.units = 5'd1;  e.bits = 24'h800000; end
      8'h46: begin e.units = 5'd9;  e.bits = 24'hAE8000; end
      8'h47: begin e.units = 5'd9;  e.bits = 24'hEE8000; end
      8'h48: begin e.units = 5'd7;  e.bits = 24'hAA0000; end
      8'h49: begin e.units = 5'd3;  e.bits = 24'hA00000; end
      8'h4A: begin e.units = 5'd13; e.bits = 24'hBBB800; end
      8'h4B: begin e.units = 5'd9;  e.bits = 24'hEB8000; end
      8'h4C: begin e.units = 5'd9;  e.bits = 24'hBA8000; end
      8'h4D: begin e.units = 5'd7;  e.bits = 24'hEE0000; end
      8'h4E: begin e.units = 5'd5;  e.bits = 24'hE80000; end
      8'h4F: begin e.units = 5'd11; e.bits = 24'hEEE000; end
      8'h50: begin e.units = 5'd11; e.bits = 24'hBBA000; end
      8'h51: begin e.units = 5'd13; e.bits = 24'hEEB800; end
      8'h52: begin e.units = 5'd7;  e.bits = 24'hBA0000; end
      8'h53: begin e.units = 5'd5;  e.bits = 24'hA80000; end
      8'h54: begin e.units = 5'd3;  e.bits = 24'hE00000; end
      8'h55: begin e.units = 5'd7;  e.bits = 24'hAE0000; end
      8'h56: begin e.units = 5'd9;  e.bits = 24'hAB8000; end
      8'h57: begin e.units = 5'd9;  e.bits = 24'hBB8000; end
      8'h58: begin e.units = 5'd11; e.bits = 24'hEAE000; end
      8'h59: begin e.units = 5'd13; e.bits = 24'hEBB800; end
      8'h5A: begin e.units = 5'd11; e.bits = 24'hEEA000; end
      8'h31: begin e.units = 5'd17; e.bits = 24'hBBBB80; end
      8'h32: begin e.units = 5'd15; e.bits = 24'hAEEE00; end
      8'h33: begin e.units = 5'd13; e.bits = 24'hABB800; end
      8'h34: begin e.units = 5'd11; e.bits = 24'hAAE000; end
      8'h35: begin e.units = 5'd9;  e.bits = 24'hAA8000; end
      8'h36: begin e.units = 5'd11; e.bits = 24'hEAA000; end
      8'h37: begin e.units = 5'd13; e.bits = 24'hEEA800; end
      8'h38: begin e.units = 5'd15; e.bits = 24'hEEEA00; end
      8'h39: begin e.units = 5'd17; e.bits = 24'hEEEE80; end
      8'h30: begin e.units = 5'd19; e.bits = 24'hEEEEE0; end
      8'h2E: begin e.units = 5'd17; e.bits = 24'hBAEB80; end
      8'h2C: begin e.units = 5'd19; e.bits = 24'hEEAEE0; end
      8'h3B: begin e.units = 5'd17; e.bits = 24'hEBAE80; end
      8'h3F: begin e.units = 5'd15; e.bits = 24'hAEEA00; end
      8'h25: begin e.units = 5'd13; e.bits = 24'hEAE800; end
      8'hC7: begin e.units = 5'd13; e.bits = 24'hEBA800; end
      8'hC9: begin e.units = 5'd11; e.bits = 24'hAEA000; end
      8'h28: begin e.units = 5'd19; e.bits = 24'hEBBAE0; end
      8'h29: begin e.units = 5'd19; e.bits = 24'hEBBAE0; end
      8'h40: begin e.units = 5'd17; e.bits = 24'hBBAE80; end
      8'h2F: begin e.units = 5'd13; e.bits = 24'hEAE800; end
      8'h20: begin e.units = 5'd1;  e.bits = 24'h000000; end
      default: begin e.hit = 1'b0; e.units = '0; e.bits = '0; end
    endcase
    return e;
  endfunction

  // Dot unit in ms, 60000 / (50 * wpm) = 1200 / wpm; zero speed reads as 1 wpm.
  function automatic logic [UNIT_MS_W-1:0] unit_ms_of(input logic [WPM_W-1:0] wpm);
    logic [UNIT_MS_W-1:0] ms;
    case (wpm)
      6'd0:  ms = 11'd1200; 6'd1:  ms = 11'd1200; 6'd2:  ms = 11'd600;
      6'd3:  ms = 11'd400;  6'd4:  ms = 11'd300;  6'd5:  ms = 11'd240;
      6'd6:  ms = 11'd200;  6'd7:  ms = 11'd171;  6'd8:  ms = 11'd150;
      6'd9:  ms = 11'd133;  6'd10: ms = 11'd120;  6'd11: ms = 11'd109;
      6'd12: ms = 11'd100;  6'd13: ms = 11'd92;   6'd14: ms = 11'd85;
      6'd15: ms = 11'd80;   6'd16: ms = 11'd75;   6'd17: ms = 11'd70;
      6'd18: ms = 11'd66;   6'd19: ms = 11'd63;   6'd20: ms = 11'd60;
      6'd21: ms = 11'd57;   6'd22: ms = 11'd54;   6'd23: ms = 11'd52;
      6'd24: ms = 11'd50;   6'd25: ms = 11'd48;   6'd26: ms = 11'd46;
      6'd27: ms = 11'd44;   6'd28: ms = 11'd42;   6'd29: ms = 11'd41;
      6'd30: ms = 11'd40;   6'd31: ms = 11'd38;   6'd32: ms = 11'd37;
      6'd33: ms = 11'd36;   6'd34: ms = 11'd35;   6'd35: ms = 11'd34;
      6'd36: ms = 11'd33;   6'd37: ms = 11'd32;   6'd38: ms = 11'd31;
      6'd39: ms = 11'd30;   6'd40: ms = 11'd30;   6'd41: ms = 11'd29;
      6'd42: ms = 11'd28;   6'd43: ms = 11'd27;   6'd44: ms = 11'd27;
      6'd45: ms = 11'd26;   6'd46: ms = 11'd26;   6'd47: ms = 11'd25;
      6'd48: ms = 11'd25;   6'd49: ms = 11'd24;   6'd50: ms = 11'd24;
      6'd51: ms = 11'd23;   6'd52: ms = 11'd23;   6'd53: ms = 11'd22;
      6'd54: ms = 11'd22;   6'd55: ms = 11'd21;   6'd56: ms = 11'd21;
      6'd57: ms = 11'd21;   6'd58: ms = 11'd20;   6'd59: ms = 11'd20;
      6'd60: ms = 11'd20;   6'd61: ms = 11'd19;   6'd62: ms = 11'd19;
      6'd63: ms = 11'd19;
      default: ms = 11'd1200;
    endcase
    return ms;
  endfunction

endpackage

### src/morse_character_keyer_top.sv
// Channel   Ports                                          Handshake
// input     in_char_code                                   in_push & !in_full
// result    out_key_level, out_unit_ms, out_last_unit      out_pop & !out_empty
// config    cfg_data (words per minute)                    cfg_valid & cfg_ready
//
// A known character is loaded from the two-entry queue into the sequencer,
// which then gives one result per cycle unless the output register stalls.
// An unknown character is taken and gives no result.
// The output register stalls the sequencer when pop stays low; the queue keeps
// accepting characters until it is full. Synchronous active-low reset, speed
// resets to 20 wpm.
module morse_character_keyer_top
  import mck_pkg::*;
#(
  parameter int PATTERN_BYTES = 3,
  parameter int GAP_UNITS     = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [7:0]           in_char_code,
  output logic                 in_full,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic                 out_key_level,
  output logic [UNIT_MS_W-1:0] out_unit_ms,
  output logic                 out_last_unit,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WPM_W-1:0]     cfg_data
);

  localparam int PAT_W = PATTERN_BYTES * 8;
  localparam int ENT_W = UNITS_W + PAT_W;

  logic                 q_push, q_full, q_pop, q_empty;
  logic [ENT_W-1:0]     q_in_data, q_out_data;
  logic [UNIT_MS_W-1:0] unit_ms_r;

  // Speed register, kept as the unit duration it selects.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ms_r <= unit_ms_of(WPM_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unit_ms_r <= unit_ms_of(cfg_data);
    end
  end
  assign out_unit_ms = unit_ms_r;

  mck_front #(
    .PAT_W (PAT_W),
    .ENT_W (ENT_W)
  ) u_front (
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in_data)
  );

  mck_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out_data),
    .empty     (q_empty)
  );

  mck_back #(
    .PAT_W     (PAT_W),
    .ENT_W     (ENT_W),
    .GAP_UNITS (GAP_UNITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_out_data),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_key_level (out_key_level),
    .out_last_unit (out_last_unit)
  );

endmodule

### src/mck_front.sv
module mck_front
  import mck_pkg::*;
#(
  parameter int PAT_W = 24,
  parameter int ENT_W = UNITS_W + 24
) (
  input  logic             in_push,
  input  logic [7:0]       in_char_code,
  output logic             in_full,
  input  logic             q_full,
  output logic             q_push,
  output logic [ENT_W-1:0] q_data
);

  // Longest pattern the store can hold, capped to the length field.
  localparam logic [UNITS_W-1:0] PAT_CAP = (PAT_W > 31) ? 5'd31 : UNITS_W'(PAT_W);

  logic [7:0]         ch_fold;
  code_entry_t        ent;
  logic [UNITS_W-1:0] len;
  logic [PAT_W-1:0]   pat;

  // Fold lower case and look the character up.
  always_comb begin
    ch_fold = in_char_code;
    if (in_char_code >= CH_LOWER_A && in_char_code <= CH_LOWER_Z) begin
      ch_fold = in_char_code - CASE_OFFSET;
    end
    ent = code_lookup(ch_fold);
    len = (ent.units > PAT_CAP) ? PAT_CAP : ent.units;
  end

  // Fit the stored pattern to the pattern store, MSB aligned.
  if (PAT_W > STORED_W) begin : g_wide
    assign pat = {ent.bits, {(PAT_W - STORED_W){1'b0}}};
  end else if (PAT_W == STORED_W) begin : g_same
    assign pat = ent.bits;
  end else begin : g_narrow
    assign pat = ent.bits[STORED_W-1 -: PAT_W];
  end

  // Unknown characters are taken and dropped.
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && ent.hit;
  assign q_data  = {len, pat};

endmodule

### src/mck_queue.sv
module mck_queue
  import mck_pkg::*;
#(
  parameter int WIDTH = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  `include "assert_macros.svh"

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == DEPTH_C);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Item storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `MCK_ASSERT_ALWAYS(a_q_count_max, !rst_n || count_r <= DEPTH_C, "queue count over depth")
  `MCK_ASSERT(a_q_fill, (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1), "queue count not incremented")
  `MCK_ASSERT(a_q_drain, (do_pop && !do_push) |=> count_r == $past(count_r) - CNT_W'(1), "queue count not decremented")

endmodule

### src/mck_back.sv
module mck_back
  import mck_pkg::*;
#(
  parameter int PAT_W     = 24,
  parameter int ENT_W     = UNITS_W + 24,
  parameter int GAP_UNITS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [ENT_W-1:0] q_data,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output logic             out_key_level,
  output logic             out_last_unit
);

  `include "assert_macros.svh"

  localparam int GAP_W = (GAP_UNITS > 1) ? $clog2(GAP_UNITS) : 1;
  localparam logic [GAP_W-1:0] GAP_LAST = GAP_W'(GAP_UNITS - 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t             state_r, state_nxt;
  logic [PAT_W-1:0]   pat_r, pat_nxt;
  logic [UNITS_W-1:0] cnt_r, cnt_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic               ov_r, ov_nxt;
  logic               key_r, key_nxt;
  logic               last_r, last_nxt;
  logic               can_load;

  assign can_load = !ov_r || out_pop;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  // Sequencer: pattern units MSB first, then the trailing gap units.
  always_comb begin
    state_nxt = state_r;
    pat_nxt   = pat_r;
    cnt_nxt   = cnt_r;
    gap_nxt   = gap_r;
    ov_nxt    = ov_r && !out_pop;
    key_nxt   = key_r;
    last_nxt  = last_r;
    if (q_pop) begin
      state_nxt = ST_RUN;
      pat_nxt   = q_data[PAT_W-1:0];
      cnt_nxt   = q_data[ENT_W-1 -: UNITS_W];
      gap_nxt   = '0;
    end else if (state_r == ST_RUN && can_load) begin
      ov_nxt = 1'b1;
      if (cnt_r != '0) begin
        key_nxt  = pat_r[PAT_W-1];
        last_nxt = 1'b0;
        pat_nxt  = pat_r << 1;
        cnt_nxt  = cnt_r - UNITS_W'(1);
      end else begin
        key_nxt  = 1'b0;
        last_nxt = (gap_r == GAP_LAST);
        gap_nxt  = gap_r + GAP_W'(1);
        if (gap_r == GAP_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    pat_r  <= pat_nxt;
    cnt_r  <= cnt_nxt;
    gap_r  <= gap_nxt;
    key_r  <= key_nxt;
    last_r <= last_nxt;
  end

  assign out_empty     = !ov_r;
  assign out_key_level = key_r;
  assign out_last_unit = last_r;

  `MCK_ASSERT(a_last_key_up, (ov_r && last_r) |-> !key_r, "key down on final gap unit")
  `MCK_ASSERT(a_pop_idle, q_pop |-> state_r == ST_IDLE, "queue popped while sequencing")
  `MCK_ASSERT(a_last_ends, (state_r == ST_RUN && can_load && cnt_r == '0 && gap_r == GAP_LAST && !q_pop) |=> (state_r == ST_IDLE && last_r), "character did not end on final gap")

endmodule
